FILE: sv/dru_pkg.sv
// ----------------------------------------------------------------------------
// dru_pkg
// Shared types and constants for the divide and remainder unit.
// ----------------------------------------------------------------------------
package dru_pkg;

	localparam int unsigned OpW   = 3;
	localparam int unsigned DataW = 32;
	localparam int unsigned CntW  = 5;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		OP_DIVU_W = 3'd0,
		OP_DIVS_W = 3'd1,
		OP_DIVU_L = 3'd2,
		OP_DIVS_L = 3'd3,
		OP_REMU_L = 3'd4,
		OP_REMS_L = 3'd5,
		OP_NOP6   = 3'd6,
		OP_NOP7   = 3'd7
	} op_t;

	// Classified job handed from the front end to the divider.
	typedef struct packed {
		logic              word_form;   // word form: 16-bit quotient packed with remainder
		logic              signed_form;
		logic              want_rem;    // long form writes the remainder
		logic              nop;         // unused code: all outputs zero
		logic              dz;          // divisor (as used) is zero
		logic              a_neg;       // dividend sign
		logic              q_neg;       // quotient gets negated
		logic [DataW-1:0]  a_mag;
		logic [DataW-1:0]  b_mag;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} div_state_t;

endpackage

FILE: sv/divide_remainder_unit.sv
// ----------------------------------------------------------------------------
// divide_remainder_unit
// Word and long divide/remainder with condition flags.
// ----------------------------------------------------------------------------
// Each operation passes the divider as a load, the radix-2 restoring loop
// (one quotient bit per cycle) and formatting into the output register.
// A two-entry queue in front takes new operations while the divider
// runs, and the output register holds a result while the next operation
// iterates. A new operation is loaded only after the last is formatted.
module divide_remainder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic        write_enable,
	output logic        flag_negative,
	output logic        flag_zero,
	output logic        flag_overflow,
	output logic        divide_by_zero
);

	logic          job_valid;
	logic          job_stall;
	dru_pkg::job_t job;

	dru_front u_front (
		.clk(clk), .arst_n(arst_n),
		.valid(in_valid), .stall(in_stall),
		.op(op), .dividend(dividend), .divisor(divisor),
		.job_valid(job_valid), .job_stall(job_stall), .job(job)
	);

	dru_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_stall(job_stall), .job(job),
		.valid_out(out_valid), .stall_out(out_stall),
		.result_value(result_value), .write_enable(write_enable),
		.flag_negative(flag_negative), .flag_zero(flag_zero),
		.flag_overflow(flag_overflow), .divide_by_zero(divide_by_zero)
	);

endmodule

FILE: sv/dru_front.sv
// ----------------------------------------------------------------------------
// dru_front
// Accepts operations, decodes the form and takes operand magnitudes.
// ----------------------------------------------------------------------------
module dru_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid,
	output logic                            stall,
	input  logic [dru_pkg::OpW-1:0]         op,
	input  logic [dru_pkg::DataW-1:0]       dividend,
	input  logic [dru_pkg::DataW-1:0]       divisor,
	output logic                            job_valid,
	input  logic                            job_stall,
	output dru_pkg::job_t                   job
);

	dru_pkg::job_t job_in;
	dru_pkg::job_t mem_q [dru_pkg::QueueDepth];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;
	logic [dru_pkg::DataW-1:0] b_ext;
	logic          b_neg;

	// Decode the operation and fold signs into magnitudes
	always_comb begin
		job_in = '0;
		b_ext  = divisor;
		unique case (dru_pkg::op_t'(op))
			dru_pkg::OP_DIVU_W: begin
				job_in.word_form = 1'b1;
				b_ext = {16'h0000, divisor[15:0]};
			end
			dru_pkg::OP_DIVS_W: begin
				job_in.word_form   = 1'b1;
				job_in.signed_form = 1'b1;
				b_ext = {{16{divisor[15]}}, divisor[15:0]};
			end
			dru_pkg::OP_DIVU_L: ;
			dru_pkg::OP_DIVS_L: job_in.signed_form = 1'b1;
			dru_pkg::OP_REMU_L: job_in.want_rem = 1'b1;
			dru_pkg::OP_REMS_L: begin
				job_in.signed_form = 1'b1;
				job_in.want_rem    = 1'b1;
			end
			default: job_in.nop = 1'b1;
		endcase
		b_neg = job_in.signed_form & b_ext[31];
		job_in.a_neg = job_in.signed_form & dividend[31];
		job_in.q_neg = job_in.a_neg ^ b_neg;
		job_in.a_mag = job_in.a_neg ? (32'd0 - dividend) : dividend;
		job_in.b_mag = b_neg ? (32'd0 - b_ext) : b_ext;
		job_in.dz    = (b_ext == 32'd0) & ~job_in.nop;
	end

	assign stall = (count_q == 2'd2);
	assign push  = valid & ~stall;
	assign job_valid = (count_q != 2'd0);
	assign pop   = job_valid & ~job_stall;
	assign job   = mem_q[rd_ptr_q];

	// Store beats in the queue
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: sv/dru_back.sv
// ----------------------------------------------------------------------------
// dru_back
// Radix-2 restoring divider with result formatting and output register.
// ----------------------------------------------------------------------------
module dru_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	output logic                            job_stall,
	input  dru_pkg::job_t                   job,
	output logic                            valid_out,
	input  logic                            stall_out,
	output logic [dru_pkg::DataW-1:0]       result_value,
	output logic                            write_enable,
	output logic                            flag_negative,
	output logic                            flag_zero,
	output logic                            flag_overflow,
	output logic                            divide_by_zero
);

	dru_pkg::div_state_t state_q, state_d;
	dru_pkg::job_t       job_q;
	logic [dru_pkg::DataW-1:0] quo_q;
	logic [dru_pkg::DataW-1:0] rem_q;
	logic [dru_pkg::CntW-1:0]  cnt_q;
	logic [dru_pkg::DataW:0]   rem_sh;
	logic [dru_pkg::DataW:0]   diff;
	logic                      take;
	logic                      fire;
	logic                      out_free;
	logic [dru_pkg::DataW-1:0] q_s;
	logic [dru_pkg::DataW-1:0] r_s;
	logic [dru_pkg::DataW-1:0] res_d;
	logic                      we_d, n_d, z_d, v_d, dz_d;
	logic                      ovf;

	assign out_free = ~valid_out | ~stall_out;
	assign take     = job_valid & (state_q == dru_pkg::ST_IDLE);
	assign job_stall = ~(state_q == dru_pkg::ST_IDLE);
	assign fire     = (state_q == dru_pkg::ST_DONE) & out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dru_pkg::ST_IDLE: if (job_valid) state_d = dru_pkg::ST_RUN;
			dru_pkg::ST_RUN:  if (cnt_q == '1) state_d = dru_pkg::ST_DONE;
			dru_pkg::ST_DONE: if (out_free) state_d = dru_pkg::ST_IDLE;
			default:          state_d = dru_pkg::ST_IDLE;
		endcase
	end

	// One quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, quo_q[31]};
		diff   = rem_sh - {1'b0, job_q.b_mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dru_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) cnt_q <= '0;
			else if (state_q == dru_pkg::ST_RUN) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Load operands and iterate
	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job;
			quo_q <= job.a_mag;
			rem_q <= '0;
		end else if (state_q == dru_pkg::ST_RUN) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Format result and flags
	always_comb begin
		q_s = job_q.q_neg ? (32'd0 - quo_q) : quo_q;
		r_s = job_q.a_neg ? (32'd0 - rem_q) : rem_q;
		if (job_q.signed_form) begin
			ovf = job_q.q_neg ? (quo_q > 32'h0000_8000) : (quo_q > 32'h0000_7fff);
		end else begin
			ovf = (quo_q > 32'h0000_ffff);
		end
		res_d = '0; we_d = 1'b0; n_d = 1'b0; z_d = 1'b0; v_d = 1'b0; dz_d = 1'b0;
		if (job_q.nop) begin
		end else if (job_q.dz) begin
			dz_d = 1'b1;
		end else if (job_q.word_form) begin
			if (ovf) begin
				v_d = 1'b1;
			end else begin
				res_d = {r_s[15:0], q_s[15:0]};
				we_d  = 1'b1;
				n_d   = q_s[15];
				z_d   = (q_s[15:0] == 16'h0000);
			end
		end else if (job_q.want_rem) begin
			res_d = rem_q;
			we_d  = 1'b1;
			z_d   = (rem_q == 32'd0);
		end else begin
			res_d = q_s;
			we_d  = 1'b1;
			n_d   = q_s[31];
			z_d   = (q_s == 32'd0);
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (fire) begin
			valid_out <= 1'b1;
		end else if (!stall_out) begin
			valid_out <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_value   <= res_d;
			write_enable   <= we_d;
			flag_negative  <= n_d;
			flag_zero      <= z_d;
			flag_overflow  <= v_d;
			divide_by_zero <= dz_d;
		end
	end

endmodule

FILE: sv/dru_checker.sv
// ----------------------------------------------------------------------------
// dru_checker
// Port-level checks on result beats of the divide unit.
// ----------------------------------------------------------------------------
module dru_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_value,
	input logic        write_enable,
	input logic        flag_overflow,
	input logic        flag_negative,
	input logic        divide_by_zero
);

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("stalled result changed");

	// No write with a trap or overflow
	a_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (divide_by_zero || flag_overflow) |-> !write_enable)
		else $error("write with trap");

	// Suppressed results are zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> result_value == 32'd0 && !flag_negative)
		else $error("suppressed result nonzero");

endmodule

bind divide_remainder_unit dru_checker u_dru_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.result_value(result_value), .write_enable(write_enable),
	.flag_overflow(flag_overflow), .flag_negative(flag_negative),
	.divide_by_zero(divide_by_zero)
);

FILE: sim/divide_remainder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// divide_remainder_unit_test
// Self-checking bench for the divide and remainder unit: directed corner
// operands for every operation, then random operands, with random idle and
// stall on both channels; each result beat is checked against a predictor.
// ----------------------------------------------------------------------------
module divide_remainder_unit_test;

	typedef struct {
		logic [31:0] value;
		logic        we;
		logic        n;
		logic        z;
		logic        v;
		logic        dz;
	} div_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [31:0] dividend;
	logic [31:0] divisor;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_value;
	logic        write_enable;
	logic        flag_negative;
	logic        flag_zero;
	logic        flag_overflow;
	logic        divide_by_zero;

	div_result_t pending_results[$];
	int          mismatch_count;
	int          checked_count;
	int          sent_count;
	bit          idle_enable;

	divide_remainder_unit uut (.*);

	// Generate the clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [31:0] magnitude(logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	// Predict one division result
	function automatic div_result_t predict_divide(dru_pkg::op_t code, logic [31:0] a,
			logic [31:0] d);
		div_result_t r;
		logic [31:0] b, am, bm, q, rm;
		logic        qneg;
		r = '{default: '0};
		case (code)
			dru_pkg::OP_DIVU_W, dru_pkg::OP_DIVS_W: begin
				b = {16'h0, d[15:0]};
				if (code == dru_pkg::OP_DIVS_W && b[15])
					b[31:16] = 16'hffff;
				if (b == 0) begin
					r.dz = 1'b1;
				end else if (code == dru_pkg::OP_DIVU_W) begin
					q = a / b;
					rm = a % b;
					if (q > 32'h0000ffff)
						r.v = 1'b1;
				end else begin
					am = magnitude(a);
					bm = magnitude(b);
					q = am / bm;
					rm = am % bm;
					qneg = a[31] ^ b[31];
					if ((qneg && q > 32'h8000) || (!qneg && q > 32'h7fff)) begin
						r.v = 1'b1;
					end else begin
						q = qneg ? 32'(-q) : q;
						rm = a[31] ? 32'(-rm) : rm;
					end
				end
				if (!r.dz && !r.v) begin
					r.value = {rm[15:0], q[15:0]};
					r.we = 1'b1;
					r.n = q[15];
					r.z = (q[15:0] == 16'h0);
				end
			end
			dru_pkg::OP_DIVU_L, dru_pkg::OP_DIVS_L,
			dru_pkg::OP_REMU_L, dru_pkg::OP_REMS_L: begin
				if (d == 0) begin
					r.dz = 1'b1;
				end else begin
					am = a;
					bm = d;
					qneg = 1'b0;
					if (code == dru_pkg::OP_DIVS_L || code == dru_pkg::OP_REMS_L) begin
						qneg = a[31] ^ d[31];
						am = magnitude(a);
						bm = magnitude(d);
					end
					q = am / bm;
					rm = am % bm;
					if (qneg)
						q = 32'(-q);
					r.we = 1'b1;
					if (code == dru_pkg::OP_REMU_L || code == dru_pkg::OP_REMS_L) begin
						r.value = rm;
						r.z = (rm == 0);
					end else begin
						r.value = q;
						r.n = q[31];
						r.z = (q == 0);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Send one operation beat and queue its expected result
	task automatic send_divide(dru_pkg::op_t code, logic [31:0] a, logic [31:0] d);
		while (idle_enable && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		dividend <= a;
		divisor <= d;
		pending_results.push_back(predict_divide(code, a, d));
		sent_count++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drive the result-side stall
	always @(posedge clk) begin
		out_stall <= idle_enable && ($urandom_range(99) < 7);
	end

	// Check each accepted result beat against the oldest expectation
	always @(posedge clk) begin
		div_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat %h", result_value);
			end else begin
				e = pending_results.pop_front();
				checked_count++;
				if (result_value !== e.value || write_enable !== e.we ||
						flag_negative !== e.n || flag_zero !== e.z ||
						flag_overflow !== e.v || divide_by_zero !== e.dz) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch #%0d: exp %h we%b n%b z%b v%b dz%b,",
							" got %h we%b n%b z%b v%b dz%b"},
							checked_count, e.value, e.we, e.n, e.z, e.v, e.dz,
							result_value, write_enable, flag_negative, flag_zero,
							flag_overflow, divide_by_zero);
				end
			end
		end
	end

	// Corner operands for every code, including unused ones
	task automatic test_directed();
		dru_pkg::op_t code;
		for (int c = 0; c < 8; c++) begin
			code = dru_pkg::op_t'(c);
			send_divide(code, 32'h0, 32'h0);
			send_divide(code, 32'hffffffff, 32'h1);
		end
		send_divide(dru_pkg::OP_DIVU_W, 32'h00010000, 32'h1);
		send_divide(dru_pkg::OP_DIVU_W, 32'h0000ffff, 32'hffff0001);
		send_divide(dru_pkg::OP_DIVS_W, 32'hffff8000, 32'h1);
		send_divide(dru_pkg::OP_DIVS_W, 32'h00008000, 32'hffff);
		send_divide(dru_pkg::OP_DIVS_W, 32'h00008000, 32'h1);
		send_divide(dru_pkg::OP_DIVS_W, 32'hfffffff9, 32'h2);
		send_divide(dru_pkg::OP_DIVS_L, 32'h80000000, 32'hffffffff);
		send_divide(dru_pkg::OP_REMS_L, 32'hfffffff9, 32'h2);
		send_divide(dru_pkg::OP_DIVS_L, 32'h7fffffff, 32'h80000000);
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(5))
			0: return $urandom_range(15);
			1: return 32'hffffffff - $urandom_range(15);
			2: return $urandom_range(32'hffff);
			3: return $urandom & (32'hffffffff >> $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	// Random operands, with a quiet stretch without idling
	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			idle_enable = !(i >= count / 3 && i < count / 2);
			send_divide(dru_pkg::op_t'($urandom_range(7)), random_operand(),
				random_operand());
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = dru_pkg::OP_DIVU_W;
		dividend = '0;
		divisor = '0;
		out_stall = 1'b0;
		idle_enable = 1'b1;
		mismatch_count = 0;
		checked_count = 0;
		sent_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1825);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d operations over all eight codes, checked %0d results.",
			sent_count, checked_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
